// ===== design/bcps_pkg.sv =====
package bcps_pkg;

    localparam int CoordW         = 32;
    localparam int LenW           = 33;
    localparam int SumW           = 34;
    localparam int ShareW         = 31;
    localparam int IdxW           = 16;
    localparam int MaxVerticesDef = 65536;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic [LenW-1:0]          len_t;

    typedef enum logic [1:0] {
        LEN_CP = 2'd0,
        LEN_PS = 2'd1,
        LEN_SS = 2'd2
    } len_sel_t;

    typedef enum logic [1:0] {
        EM_INNER      = 2'd0,
        EM_CLOSE_LAST = 2'd1,
        EM_CLOSE_START = 2'd2
    } emit_sel_t;

    typedef struct packed {
        logic            cap;
        logic            cap_start;
        logic            cap_second;
        logic            mids;
        logic            len_go;
        len_sel_t        len_sel;
        logic            emit_go;
        emit_sel_t       emit_sel;
        logic            out_load;
        logic            out_plain;
        logic [IdxW-1:0] out_idx;
        logic            out_last;
        logic            commit;
    } cmd_t;

    typedef struct packed {
        logic len_done;
        logic emit_done;
    } sts_t;

endpackage

// ===== design/bcps_len.sv =====
module bcps_len (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  bcps_pkg::coord_t ax,
    input  bcps_pkg::coord_t ay,
    input  bcps_pkg::coord_t bx,
    input  bcps_pkg::coord_t by,
    output logic             done,
    output bcps_pkg::len_t   len
);
    import bcps_pkg::*;

    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_SQX  = 5'b00010,
        L_SQY  = 5'b00100,
        L_ADD  = 5'b01000,
        L_ROOT = 5'b10000
    } len_state_t;

    localparam int CntW = $clog2(LenW);

    len_state_t            state_reg, state_next;
    logic [CntW-1:0]       cnt_reg;
    logic                  done_reg;
    logic [CoordW-1:0]     ux_reg, uy_reg;
    logic [2*CoordW-1:0]   sq_reg, acc_reg;
    logic [2*LenW-1:0]     rad_reg;
    logic [LenW+1:0]       rem_reg;
    logic [LenW-1:0]       root_reg;
    logic signed [CoordW:0] dx, dy;
    logic [2*CoordW-1:0]   sq_x, sq_y;
    logic [LenW+3:0]       rem_sh, trial, rem_sub;
    logic                  ge;

    function automatic logic [CoordW-1:0] mag_of(input logic signed [CoordW:0] d);
        logic signed [CoordW:0] n;
        n = -d;
        mag_of = d[CoordW] ? n[CoordW-1:0] : d[CoordW-1:0];
    endfunction

    assign dx      = {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
    assign dy      = {by[CoordW-1], by} - {ay[CoordW-1], ay};
    assign sq_x    = ux_reg * ux_reg;
    assign sq_y    = uy_reg * uy_reg;
    assign rem_sh  = {rem_reg, rad_reg[2*LenW-1:2*LenW-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = ge ? rem_sh - trial : rem_sh;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE: if (go) state_next = L_SQX;
            L_SQX:  state_next = L_SQY;
            L_SQY:  state_next = L_ADD;
            L_ADD:  state_next = L_ROOT;
            L_ROOT: if (cnt_reg == '0) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_ROOT) && (cnt_reg == '0);
            if (state_reg == L_ADD)
                cnt_reg <= CntW'(LenW - 1);
            else if (state_reg == L_ROOT)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (go)
                begin
                    ux_reg <= mag_of(dx);
                    uy_reg <= mag_of(dy);
                end
            end
            L_SQX: sq_reg <= sq_x;
            L_SQY:
            begin
                acc_reg <= sq_reg;
                sq_reg  <= sq_y;
            end
            L_ADD:
            begin
                rad_reg  <= {1'b0, {1'b0, acc_reg} + {1'b0, sq_reg}};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            L_ROOT:
            begin
                rad_reg  <= {rad_reg[2*LenW-3:0], 2'b00};
                rem_reg  <= rem_sub[LenW+1:0];
                root_reg <= {root_reg[LenW-2:0], ge};
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign len  = root_reg;

endmodule

// ===== design/bcps_emit.sv =====
module bcps_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  bcps_pkg::coord_t px,
    input  bcps_pkg::coord_t py,
    input  bcps_pkg::coord_t ax,
    input  bcps_pkg::coord_t ay,
    input  bcps_pkg::coord_t bx,
    input  bcps_pkg::coord_t by,
    input  bcps_pkg::len_t   n1,
    input  bcps_pkg::len_t   n2,
    output logic             done,
    output bcps_pkg::coord_t left_x,
    output bcps_pkg::coord_t left_y,
    output bcps_pkg::coord_t right_x,
    output bcps_pkg::coord_t right_y
);
    import bcps_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_DIV  = 4'b0010,
        E_MUL  = 4'b0100,
        E_SUM  = 4'b1000
    } emit_state_t;

    localparam int CntW  = $clog2(ShareW);
    localparam int ProdW = LenW + 16;
    localparam int OffW  = LenW + 1;
    localparam int SatW  = CoordW + 3;

    emit_state_t             state_reg, state_next;
    logic [CntW-1:0]         cnt_reg;
    logic [1:0]              lane_reg, ph_reg;
    logic                    done_reg;
    logic [LenW-1:0]         mvx_reg, mvy_reg;
    logic                    negx_reg, negy_reg, zero_reg;
    logic [SumW-1:0]         sum_reg;
    logic [SumW:0]           r1_reg, r2_reg;
    logic [ShareW-1:0]       q1_reg, q2_reg;
    logic [ProdW-1:0]        prod_reg, lo_reg;
    logic signed [OffW-1:0]  off_reg [4];
    coord_t                  lx_reg, ly_reg, rx_reg, ry_reg;
    logic signed [LenW-1:0]  vx, vy;
    logic [LenW-1:0]         nvx, nvy;
    logic                    ge1, ge2;
    logic [SumW:0]           d1, d2;
    logic [LenW-1:0]         m;
    logic [ShareW-1:0]       sh;
    logic [15:0]             half;
    logic [ProdW-1:0]        prod;
    logic [63:0]             full;
    logic [LenW-1:0]         rmag;
    logic                    neg;
    logic [OffW-1:0]         pos_off;

    function automatic coord_t sat(input logic signed [SatW-1:0] v);
        if (v[SatW-1:CoordW-1] == '0 || v[SatW-1:CoordW-1] == '1)
            sat = v[CoordW-1:0];
        else if (v[SatW-1])
            sat = {1'b1, {(CoordW-1){1'b0}}};
        else
            sat = {1'b0, {(CoordW-1){1'b1}}};
    endfunction

    function automatic logic signed [SatW-1:0] ext_p(input coord_t p);
        ext_p = {{(SatW-CoordW){p[CoordW-1]}}, p};
    endfunction

    function automatic logic signed [SatW-1:0] ext_o(input logic signed [OffW-1:0] o);
        ext_o = {{(SatW-OffW){o[OffW-1]}}, o};
    endfunction

    assign vx  = {bx[CoordW-1], bx} - {ax[CoordW-1], ax};
    assign vy  = {by[CoordW-1], by} - {ay[CoordW-1], ay};
    assign nvx = -vx;
    assign nvy = -vy;

    assign ge1 = !zero_reg && (r1_reg >= {1'b0, sum_reg});
    assign ge2 = !zero_reg && (r2_reg >= {1'b0, sum_reg});
    assign d1  = ge1 ? r1_reg - {1'b0, sum_reg} : r1_reg;
    assign d2  = ge2 ? r2_reg - {1'b0, sum_reg} : r2_reg;

    assign m       = lane_reg[0] ? mvy_reg : mvx_reg;
    assign neg     = lane_reg[0] ? negy_reg : negx_reg;
    assign sh      = lane_reg[1] ? q2_reg : q1_reg;
    assign half    = (ph_reg == 2'd0) ? sh[15:0] : {1'b0, sh[ShareW-1:16]};
    assign prod    = m * half;
    assign full    = {{(64-ProdW){1'b0}}, lo_reg} + {prod_reg[47:0], 16'h0000}
                     + 64'h0000_0000_2000_0000;
    assign rmag    = full[62:30];
    assign pos_off = {1'b0, rmag};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE: if (go) state_next = E_DIV;
            E_DIV:  if (cnt_reg == '0) state_next = E_MUL;
            E_MUL:  if (lane_reg == 2'd3 && ph_reg == 2'd2) state_next = E_SUM;
            E_SUM:  state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
            lane_reg  <= 2'd0;
            ph_reg    <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == E_SUM);
            if (state_reg == E_IDLE && go)
            begin
                cnt_reg  <= CntW'(ShareW - 1);
                lane_reg <= 2'd0;
                ph_reg   <= 2'd0;
            end
            else if (state_reg == E_DIV)
                cnt_reg <= cnt_reg - 1'b1;
            else if (state_reg == E_MUL)
            begin
                if (ph_reg == 2'd2)
                begin
                    ph_reg   <= 2'd0;
                    lane_reg <= lane_reg + 1'b1;
                end
                else
                    ph_reg <= ph_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            E_IDLE:
            begin
                if (go)
                begin
                    mvx_reg  <= vx[LenW-1] ? nvx : vx;
                    mvy_reg  <= vy[LenW-1] ? nvy : vy;
                    negx_reg <= vx[LenW-1];
                    negy_reg <= vy[LenW-1];
                    sum_reg  <= {1'b0, n1} + {1'b0, n2};
                    zero_reg <= (n1 == '0) && (n2 == '0);
                    r1_reg   <= {2'b00, n1};
                    r2_reg   <= {2'b00, n2};
                end
            end
            E_DIV:
            begin
                r1_reg <= {d1[SumW-1:0], 1'b0};
                r2_reg <= {d2[SumW-1:0], 1'b0};
                q1_reg <= {q1_reg[ShareW-2:0], ge1};
                q2_reg <= {q2_reg[ShareW-2:0], ge2};
            end
            E_MUL:
            begin
                if (ph_reg == 2'd0)
                    prod_reg <= prod;
                else if (ph_reg == 2'd1)
                begin
                    lo_reg   <= prod_reg;
                    prod_reg <= prod;
                end
                else
                    off_reg[lane_reg] <= neg ? -pos_off : pos_off;
            end
            E_SUM:
            begin
                lx_reg <= sat(ext_p(px) - ext_o(off_reg[0]));
                ly_reg <= sat(ext_p(py) - ext_o(off_reg[1]));
                rx_reg <= sat(ext_p(px) + ext_o(off_reg[2]));
                ry_reg <= sat(ext_p(py) + ext_o(off_reg[3]));
            end
            default: ;
        endcase
    end

    assign done    = done_reg;
    assign left_x  = lx_reg;
    assign left_y  = ly_reg;
    assign right_x = rx_reg;
    assign right_y = ry_reg;

endmodule

// ===== design/bcps_dp.sv =====
module bcps_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcps_pkg::coord_t              point_x,
    input  bcps_pkg::coord_t              point_y,
    input  bcps_pkg::cmd_t                cmd,
    output bcps_pkg::sts_t                sts,
    output logic [bcps_pkg::IdxW-1:0]     vertex_index,
    output bcps_pkg::coord_t              left_x,
    output bcps_pkg::coord_t              left_y,
    output bcps_pkg::coord_t              right_x,
    output bcps_pkg::coord_t              right_y,
    output logic                          last_result
);
    import bcps_pkg::*;

    coord_t in_x_reg, in_y_reg, start_x_reg, start_y_reg, second_x_reg, second_y_reg;
    coord_t center_x_reg, center_y_reg, pmid_x_reg, pmid_y_reg;
    coord_t mb_x_reg, mb_y_reg, mc_x_reg, mc_y_reg, ms_x_reg, ms_y_reg;
    len_t   plen_reg, n2_reg, nc_reg, ns_reg;
    coord_t lax, lay, lbx, lby;
    coord_t epx, epy, eax, eay, ebx, eby;
    len_t   en1, en2, len;
    coord_t elx, ely, erx, ery;
    logic   len_done, emit_done;
    logic [IdxW-1:0] idx_reg;
    logic   last_reg;
    coord_t olx_reg, oly_reg, orx_reg, ory_reg;

    function automatic coord_t mid(input coord_t a, input coord_t b);
        logic signed [CoordW:0] s;
        s = {a[CoordW-1], a} + {b[CoordW-1], b};
        mid = s[CoordW:1];
    endfunction

    always_comb
    begin
        case (cmd.len_sel)
            LEN_CP:
            begin
                lax = center_x_reg; lay = center_y_reg; lbx = in_x_reg; lby = in_y_reg;
            end
            LEN_PS:
            begin
                lax = in_x_reg; lay = in_y_reg; lbx = start_x_reg; lby = start_y_reg;
            end
            default:
            begin
                lax = start_x_reg; lay = start_y_reg; lbx = second_x_reg; lby = second_y_reg;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.emit_sel)
            EM_INNER:
            begin
                epx = center_x_reg; epy = center_y_reg;
                eax = pmid_x_reg;   eay = pmid_y_reg;   en1 = plen_reg;
                ebx = mb_x_reg;     eby = mb_y_reg;     en2 = n2_reg;
            end
            EM_CLOSE_LAST:
            begin
                epx = in_x_reg;     epy = in_y_reg;
                eax = mb_x_reg;     eay = mb_y_reg;     en1 = n2_reg;
                ebx = mc_x_reg;     eby = mc_y_reg;     en2 = nc_reg;
            end
            default:
            begin
                epx = start_x_reg;  epy = start_y_reg;
                eax = mc_x_reg;     eay = mc_y_reg;     en1 = nc_reg;
                ebx = ms_x_reg;     eby = ms_y_reg;     en2 = ns_reg;
            end
        endcase
    end

    bcps_len u_len (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.len_go),
        .ax    (lax),
        .ay    (lay),
        .bx    (lbx),
        .by    (lby),
        .done  (len_done),
        .len   (len)
    );

    bcps_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (cmd.emit_go),
        .px      (epx),
        .py      (epy),
        .ax      (eax),
        .ay      (eay),
        .bx      (ebx),
        .by      (eby),
        .n1      (en1),
        .n2      (en2),
        .done    (emit_done),
        .left_x  (elx),
        .left_y  (ely),
        .right_x (erx),
        .right_y (ery)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            in_x_reg <= point_x;
            in_y_reg <= point_y;
        end
        if (cmd.cap_start)
        begin
            start_x_reg  <= point_x;
            start_y_reg  <= point_y;
            center_x_reg <= point_x;
            center_y_reg <= point_y;
        end
        if (cmd.cap_second)
        begin
            second_x_reg <= point_x;
            second_y_reg <= point_y;
        end
        if (cmd.mids)
        begin
            mb_x_reg <= mid(center_x_reg, in_x_reg);
            mb_y_reg <= mid(center_y_reg, in_y_reg);
            mc_x_reg <= mid(in_x_reg, start_x_reg);
            mc_y_reg <= mid(in_y_reg, start_y_reg);
            ms_x_reg <= mid(start_x_reg, second_x_reg);
            ms_y_reg <= mid(start_y_reg, second_y_reg);
        end
        if (len_done)
        begin
            case (cmd.len_sel)
                LEN_CP:  n2_reg <= len;
                LEN_PS:  nc_reg <= len;
                default: ns_reg <= len;
            endcase
        end
        if (cmd.commit)
        begin
            pmid_x_reg   <= mb_x_reg;
            pmid_y_reg   <= mb_y_reg;
            plen_reg     <= n2_reg;
            center_x_reg <= in_x_reg;
            center_y_reg <= in_y_reg;
        end
        if (cmd.out_load)
        begin
            idx_reg  <= cmd.out_idx;
            last_reg <= cmd.out_last;
            olx_reg  <= cmd.out_plain ? in_x_reg : elx;
            oly_reg  <= cmd.out_plain ? in_y_reg : ely;
            orx_reg  <= cmd.out_plain ? in_x_reg : erx;
            ory_reg  <= cmd.out_plain ? in_y_reg : ery;
        end
    end

    assign sts.len_done  = len_done;
    assign sts.emit_done = emit_done;
    assign vertex_index  = idx_reg;
    assign last_result   = last_reg;
    assign left_x        = olx_reg;
    assign left_y        = oly_reg;
    assign right_x       = orx_reg;
    assign right_y       = ory_reg;

endmodule

// ===== design/bcps_ctrl.sv =====
module bcps_ctrl #(
    parameter int MAX_VERTICES = bcps_pkg::MaxVerticesDef
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           final_point,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           closed_curve,
    output logic           out_valid,
    input  logic           out_ready,
    output bcps_pkg::cmd_t cmd,
    input  bcps_pkg::sts_t sts
);
    import bcps_pkg::*;

    localparam int CW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [1:0] SUB_GO   = 2'd0;
    localparam logic [1:0] SUB_WAIT = 2'd1;
    localparam logic [1:0] SUB_OUT  = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_FIRST    = 11'b00000000010,
        S_MID      = 11'b00000000100,
        S_LEN_B    = 11'b00000001000,
        S_EMIT_IN  = 11'b00000010000,
        S_END_OPEN = 11'b00000100000,
        S_LEN_C    = 11'b00001000000,
        S_LEN_S    = 11'b00010000000,
        S_EMIT_CL  = 11'b00100000000,
        S_EMIT_CS  = 11'b01000000000,
        S_COMMIT   = 11'b10000000000
    } ctrl_state_t;

    ctrl_state_t     state_reg, state_next, after_inner;
    logic [1:0]      sub_reg, sub_next;
    logic [CW-1:0]   count_reg, count_next, idx_reg, idx_m1;
    logic            fin_reg, closed_reg, mode_reg, out_valid_reg, out_valid_next;
    logic            fin_in, out_free, accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign fin_in    = final_point || (count_reg == CW'(MAX_VERTICES - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign idx_m1    = idx_reg - CW'(1);
    assign after_inner = fin_reg ? (closed_reg ? S_LEN_C : S_END_OPEN) : S_COMMIT;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        sub_next   = sub_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap        = 1'b1;
                    cmd.cap_start  = (count_reg == '0);
                    cmd.cap_second = (count_reg == CW'(1));
                    if (count_reg == '0)
                    begin
                        count_next = fin_in ? '0 : CW'(1);
                        state_next = (!mode_reg || fin_in) ? S_FIRST : S_IDLE;
                    end
                    else
                        state_next = S_MID;
                end
            end
            S_FIRST:
            begin
                cmd.out_plain = 1'b1;
                cmd.out_last  = fin_reg;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MID:
            begin
                cmd.mids   = 1'b1;
                sub_next   = SUB_GO;
                state_next = S_LEN_B;
            end
            S_LEN_B, S_LEN_C, S_LEN_S:
            begin
                cmd.len_sel = (state_reg == S_LEN_B) ? LEN_CP :
                              (state_reg == S_LEN_C) ? LEN_PS : LEN_SS;
                if (sub_reg == SUB_GO)
                begin
                    cmd.len_go = 1'b1;
                    sub_next   = SUB_WAIT;
                end
                else if (sts.len_done)
                begin
                    sub_next = SUB_GO;
                    if (state_reg == S_LEN_B)
                        state_next = (idx_reg > CW'(1)) ? S_EMIT_IN : after_inner;
                    else if (state_reg == S_LEN_C)
                        state_next = S_LEN_S;
                    else
                        state_next = S_EMIT_CL;
                end
            end
            S_EMIT_IN, S_EMIT_CL, S_EMIT_CS:
            begin
                cmd.emit_sel = (state_reg == S_EMIT_IN) ? EM_INNER :
                               (state_reg == S_EMIT_CL) ? EM_CLOSE_LAST : EM_CLOSE_START;
                cmd.out_idx  = (state_reg == S_EMIT_IN) ? IdxW'(idx_m1) :
                               (state_reg == S_EMIT_CL) ? IdxW'(idx_reg) : '0;
                cmd.out_last = (state_reg == S_EMIT_CS);
                case (sub_reg)
                    SUB_GO:
                    begin
                        cmd.emit_go = 1'b1;
                        sub_next    = SUB_WAIT;
                    end
                    SUB_WAIT:
                    begin
                        if (sts.emit_done)
                            sub_next = SUB_OUT;
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            cmd.out_load = 1'b1;
                            sub_next     = SUB_GO;
                            if (state_reg == S_EMIT_IN)
                                state_next = after_inner;
                            else if (state_reg == S_EMIT_CL)
                                state_next = S_EMIT_CS;
                            else
                                state_next = S_COMMIT;
                        end
                    end
                endcase
            end
            S_END_OPEN:
            begin
                cmd.out_plain = 1'b1;
                cmd.out_idx   = IdxW'(idx_reg);
                cmd.out_last  = 1'b1;
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (fin_reg)
                    count_next = '0;
                else
                begin
                    cmd.commit = 1'b1;
                    count_next = idx_reg + CW'(1);
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sub_reg       <= SUB_GO;
            count_reg     <= '0;
            idx_reg       <= '0;
            fin_reg       <= 1'b0;
            closed_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sub_reg       <= sub_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                mode_reg <= closed_curve;
            if (accept)
            begin
                idx_reg    <= count_reg;
                fin_reg    <= fin_in;
                closed_reg <= mode_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/bezier_control_point_smoother_unit.sv =====
// Bezier control point smoother.
// Input channel (in_valid/in_ready): one polyline vertex per word, point_x and
// point_y in signed Q16.16, final_point set on the last vertex.
// Output channel (out_valid/out_ready): one word per vertex with vertex_index,
// the left and right control points (saturated Q16.16) and last_result set on
// the final word of the polyline.
// Config channel (cfg_valid/cfg_ready): closed_curve, write only while idle.
// The block works on one vertex at a time. The work on an inner vertex is
// dominated by the 33-step square root of the edge length and the 31-step
// share divide; the last vertex of a closed polyline runs three lengths and
// three results.
// A result is held in the output register while the next vertex is accepted
// and worked on; a stalled receiver only holds the block when the next result
// is ready to load.
// Reset clears the vertex count, the mode register and the output valid.
module bezier_control_point_smoother_unit #(
    parameter int MAX_VERTICES = bcps_pkg::MaxVerticesDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [bcps_pkg::CoordW-1:0] point_x,
    input  logic signed [bcps_pkg::CoordW-1:0] point_y,
    input  logic                          final_point,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          closed_curve,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bcps_pkg::IdxW-1:0]     vertex_index,
    output logic signed [bcps_pkg::CoordW-1:0] left_x,
    output logic signed [bcps_pkg::CoordW-1:0] left_y,
    output logic signed [bcps_pkg::CoordW-1:0] right_x,
    output logic signed [bcps_pkg::CoordW-1:0] right_y,
    output logic                          last_result
);
    import bcps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bcps_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .final_point  (final_point),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .closed_curve (closed_curve),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    bcps_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_x      (point_x),
        .point_y      (point_y),
        .cmd          (cmd),
        .sts          (sts),
        .vertex_index (vertex_index),
        .left_x       (left_x),
        .left_y       (left_y),
        .right_x      (right_x),
        .right_y      (right_y),
        .last_result  (last_result)
    );

`ifndef ASSERT_OFF
    ap_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result loaded over a waiting word");

    ap_len_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.len_done |-> !in_ready)
        else $error("length finished with no vertex in work");

    ap_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.emit_done |-> !in_ready)
        else $error("control points finished with no vertex in work");
`endif

endmodule
